// File: src/cpu_alu_8bit_flags_core_assert.svh
// Assertion macros used by the ALU core top level.
`ifndef CPU_ALU_8BIT_FLAGS_CORE_ASSERT_SVH
`define CPU_ALU_8BIT_FLAGS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CALU_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in ALU core");
`define CALU_ASSERT(lbl, prop) `CALU_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define CALU_ASSERT_CLK(lbl, clk, rst_n, prop)
`define CALU_ASSERT(lbl, prop)
`endif

`endif

// File: src/calu_pkg.sv
// Types and codes shared by the ALU core pipeline stages.
package calu_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_CP   = 5'd4,
    OP_AND  = 5'd5,
    OP_OR   = 5'd6,
    OP_XOR  = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLC  = 5'd10,
    OP_RRC  = 5'd11,
    OP_RL   = 5'd12,
    OP_RR   = 5'd13,
    OP_SWAP = 5'd14,
    OP_SET  = 5'd15,
    OP_RES  = 5'd16,
    OP_CPL  = 5'd17
  } op_e;

  typedef enum logic [3:0] {
    U_ARITH = 4'd0,
    U_AND   = 4'd1,
    U_OR    = 4'd2,
    U_XOR   = 4'd3,
    U_RLC   = 4'd4,
    U_RRC   = 4'd5,
    U_RL    = 4'd6,
    U_RR    = 4'd7,
    U_SWAP  = 4'd8,
    U_CPL   = 4'd9,
    U_PASS  = 4'd10
  } unit_e;

  typedef enum logic [2:0] {
    FM_ARITH  = 3'd0,
    FM_INCDEC = 3'd1,
    FM_AND    = 3'd2,
    FM_ZC     = 3'd3,
    FM_CPL    = 3'd4,
    FM_PASS   = 3'd5
  } fmode_e;

  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef struct packed {
    logic [4:0] operation;
    logic [7:0] accumulator;
    logic [7:0] operand;
    logic [2:0] bit_index;
    logic [3:0] flags_in;
  } in_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
  } out_t;

  typedef struct packed {
    unit_e      unit;
    fmode_e     fmode;
    logic [7:0] x;
    logic [7:0] y;
    logic       cin;
    logic       sub;
    logic       res_acc;
    logic [3:0] flags;
  } dec_t;

  typedef struct packed {
    logic [7:0] r;
    logic       c;
    logic       h;
    logic       n;
    fmode_e     fmode;
    logic       res_acc;
    logic [7:0] acc;
    logic [3:0] flags;
  } exe_t;

  typedef struct packed {
    logic valid;
    logic stall;
  } hs_t;

endpackage

// File: src/cpu_alu_8bit_flags_core.sv
// Top level of the 8-bit ALU with Z, N, H and C flags: three-stage pipeline.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (calu_pkg::in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (calu_pkg::out_t)
//
// Each transaction passes the decode, execute and flag registers in that order.
// One transaction enters per cycle unless in_stall_o is high.
// A stall holds only the full stages; bubbles collapse, so input keeps flowing while any stage is empty.
// Reset empties all stages; no output is presented after reset until data arrives.
`include "cpu_alu_8bit_flags_core_assert.svh"

module cpu_alu_8bit_flags_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  calu_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output calu_pkg::out_t out_data_o
);

  calu_pkg::hs_t  hs_dec;
  calu_pkg::hs_t  hs_exe;
  calu_pkg::hs_t  hs_flg;
  calu_pkg::dec_t dec;
  calu_pkg::exe_t exe;

  calu_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .stall_i (hs_exe.stall),
    .hs_o    (hs_dec),
    .dec_o   (dec)
  );

  calu_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hs_dec.valid),
    .dec_i   (dec),
    .stall_i (hs_flg.stall),
    .hs_o    (hs_exe),
    .exe_o   (exe)
  );

  calu_flags u_flags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hs_exe.valid),
    .exe_i   (exe),
    .stall_i (out_stall_i),
    .hs_o    (hs_flg),
    .out_o   (out_data_o)
  );

  assign in_stall_o  = hs_dec.stall;
  assign out_valid_o = hs_flg.valid;

  `CALU_ASSERT(a_stall_only_when_out_blocked, in_stall_o |-> (out_valid_o && out_stall_i))
  `CALU_ASSERT(a_dec_to_exe_kept, (hs_dec.valid && !hs_exe.stall) |=> hs_exe.valid)
  `CALU_ASSERT(a_exe_to_flg_kept, (hs_exe.valid && !hs_flg.stall) |=> hs_flg.valid)

endmodule

// File: src/calu_decode.sv
// Stage one: operation decode and adder operand preparation.
module calu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  calu_pkg::in_t item_i,
  input  logic          stall_i,
  output calu_pkg::hs_t hs_o,
  output calu_pkg::dec_t dec_o
);

  logic           valid_q;
  logic           stall;
  calu_pkg::dec_t dec_d;
  calu_pkg::dec_t dec_q;
  logic [7:0]     mask;
  logic           cin;

  assign stall = valid_q && stall_i;
  assign mask  = 8'b1 << item_i.bit_index;
  assign cin   = item_i.flags_in[calu_pkg::FlagC];

  always_comb begin
    dec_d.unit    = calu_pkg::U_PASS;
    dec_d.fmode   = calu_pkg::FM_PASS;
    dec_d.x       = item_i.accumulator;
    dec_d.y       = item_i.operand;
    dec_d.cin     = 1'b0;
    dec_d.sub     = 1'b0;
    dec_d.res_acc = 1'b0;
    dec_d.flags   = item_i.flags_in;
    case (item_i.operation)
      calu_pkg::OP_ADD: begin
        dec_d.unit  = calu_pkg::U_ARITH;
        dec_d.fmode = calu_pkg::FM_ARITH;
      end
      calu_pkg::OP_ADC: begin
        dec_d.unit  = calu_pkg::U_ARITH;
        dec_d.fmode = calu_pkg::FM_ARITH;
        dec_d.cin   = cin;
      end
      calu_pkg::OP_SUB: begin
        dec_d.unit  = calu_pkg::U_ARITH;
        dec_d.fmode = calu_pkg::FM_ARITH;
        dec_d.y     = ~item_i.operand;
        dec_d.cin   = 1'b1;
        dec_d.sub   = 1'b1;
      end
      calu_pkg::OP_SBC: begin
        dec_d.unit  = calu_pkg::U_ARITH;
        dec_d.fmode = calu_pkg::FM_ARITH;
        dec_d.y     = ~item_i.operand;
        dec_d.cin   = ~cin;
        dec_d.sub   = 1'b1;
      end
      calu_pkg::OP_CP: begin
        dec_d.unit    = calu_pkg::U_ARITH;
        dec_d.fmode   = calu_pkg::FM_ARITH;
        dec_d.y       = ~item_i.operand;
        dec_d.cin     = 1'b1;
        dec_d.sub     = 1'b1;
        dec_d.res_acc = 1'b1;
      end
      calu_pkg::OP_AND: begin
        dec_d.unit  = calu_pkg::U_AND;
        dec_d.fmode = calu_pkg::FM_AND;
      end
      calu_pkg::OP_OR: begin
        dec_d.unit  = calu_pkg::U_OR;
        dec_d.fmode = calu_pkg::FM_ZC;
      end
      calu_pkg::OP_XOR: begin
        dec_d.unit  = calu_pkg::U_XOR;
        dec_d.fmode = calu_pkg::FM_ZC;
      end
      calu_pkg::OP_INC: begin
        dec_d.unit  = calu_pkg::U_ARITH;
        dec_d.fmode = calu_pkg::FM_INCDEC;
        dec_d.x     = item_i.operand;
        dec_d.y     = 8'h00;
        dec_d.cin   = 1'b1;
      end
      calu_pkg::OP_DEC: begin
        dec_d.unit  = calu_pkg::U_ARITH;
        dec_d.fmode = calu_pkg::FM_INCDEC;
        dec_d.x     = item_i.operand;
        dec_d.y     = 8'hFF;
        dec_d.sub   = 1'b1;
      end
      calu_pkg::OP_RLC: begin
        dec_d.unit  = calu_pkg::U_RLC;
        dec_d.fmode = calu_pkg::FM_ZC;
        dec_d.x     = item_i.operand;
      end
      calu_pkg::OP_RRC: begin
        dec_d.unit  = calu_pkg::U_RRC;
        dec_d.fmode = calu_pkg::FM_ZC;
        dec_d.x     = item_i.operand;
      end
      calu_pkg::OP_RL: begin
        dec_d.unit  = calu_pkg::U_RL;
        dec_d.fmode = calu_pkg::FM_ZC;
        dec_d.x     = item_i.operand;
      end
      calu_pkg::OP_RR: begin
        dec_d.unit  = calu_pkg::U_RR;
        dec_d.fmode = calu_pkg::FM_ZC;
        dec_d.x     = item_i.operand;
      end
      calu_pkg::OP_SWAP: begin
        dec_d.unit  = calu_pkg::U_SWAP;
        dec_d.fmode = calu_pkg::FM_ZC;
        dec_d.x     = item_i.operand;
      end
      calu_pkg::OP_SET: begin
        dec_d.unit = calu_pkg::U_OR;
        dec_d.x    = item_i.operand;
        dec_d.y    = mask;
      end
      calu_pkg::OP_RES: begin
        dec_d.unit = calu_pkg::U_AND;
        dec_d.x    = item_i.operand;
        dec_d.y    = ~mask;
      end
      calu_pkg::OP_CPL: begin
        dec_d.unit  = calu_pkg::U_CPL;
        dec_d.fmode = calu_pkg::FM_CPL;
        dec_d.x     = item_i.operand;
      end
      default: begin
        dec_d.unit = calu_pkg::U_PASS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      dec_q <= dec_d;
    end
  end

  assign hs_o.valid = valid_q;
  assign hs_o.stall = stall;
  assign dec_o      = dec_q;

endmodule

// File: src/calu_exec.sv
// Stage two: adder, logic unit, rotator, nibble swap and complement.
module calu_exec (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  calu_pkg::dec_t dec_i,
  input  logic           stall_i,
  output calu_pkg::hs_t  hs_o,
  output calu_pkg::exe_t exe_o
);

  logic           valid_q;
  logic           stall;
  calu_pkg::exe_t exe_d;
  calu_pkg::exe_t exe_q;
  logic [8:0]     sum;
  logic [4:0]     low;
  logic           cin_old;

  assign stall   = valid_q && stall_i;
  assign sum     = {1'b0, dec_i.x} + {1'b0, dec_i.y} + {8'b0, dec_i.cin};
  assign low     = {1'b0, dec_i.x[3:0]} + {1'b0, dec_i.y[3:0]} + {4'b0, dec_i.cin};
  assign cin_old = dec_i.flags[calu_pkg::FlagC];

  always_comb begin
    exe_d.r       = dec_i.x;
    exe_d.c       = 1'b0;
    exe_d.h       = low[4] ^ dec_i.sub;
    exe_d.n       = dec_i.sub;
    exe_d.fmode   = dec_i.fmode;
    exe_d.res_acc = dec_i.res_acc;
    exe_d.acc     = dec_i.x;
    exe_d.flags   = dec_i.flags;
    case (dec_i.unit)
      calu_pkg::U_ARITH: begin
        exe_d.r = sum[7:0];
        exe_d.c = sum[8] ^ dec_i.sub;
      end
      calu_pkg::U_AND:  exe_d.r = dec_i.x & dec_i.y;
      calu_pkg::U_OR:   exe_d.r = dec_i.x | dec_i.y;
      calu_pkg::U_XOR:  exe_d.r = dec_i.x ^ dec_i.y;
      calu_pkg::U_RLC: begin
        exe_d.r = {dec_i.x[6:0], dec_i.x[7]};
        exe_d.c = dec_i.x[7];
      end
      calu_pkg::U_RRC: begin
        exe_d.r = {dec_i.x[0], dec_i.x[7:1]};
        exe_d.c = dec_i.x[0];
      end
      calu_pkg::U_RL: begin
        exe_d.r = {dec_i.x[6:0], cin_old};
        exe_d.c = dec_i.x[7];
      end
      calu_pkg::U_RR: begin
        exe_d.r = {cin_old, dec_i.x[7:1]};
        exe_d.c = dec_i.x[0];
      end
      calu_pkg::U_SWAP: exe_d.r = {dec_i.x[3:0], dec_i.x[7:4]};
      calu_pkg::U_CPL:  exe_d.r = ~dec_i.x;
      default:          exe_d.r = dec_i.x;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      exe_q <= exe_d;
    end
  end

  assign hs_o.valid = valid_q;
  assign hs_o.stall = stall;
  assign exe_o      = exe_q;

endmodule

// File: src/calu_flags.sv
// Stage three: zero detect, flag assembly and result select.
module calu_flags (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  calu_pkg::exe_t exe_i,
  input  logic           stall_i,
  output calu_pkg::hs_t  hs_o,
  output calu_pkg::out_t out_o
);

  logic           valid_q;
  logic           stall;
  calu_pkg::out_t out_d;
  calu_pkg::out_t out_q;
  logic           z;

  assign stall = valid_q && stall_i;
  assign z     = (exe_i.r == 8'h00);

  always_comb begin
    out_d.result = exe_i.res_acc ? exe_i.acc : exe_i.r;
    case (exe_i.fmode)
      calu_pkg::FM_ARITH:  out_d.flags_out = {z, exe_i.n, exe_i.h, exe_i.c};
      calu_pkg::FM_INCDEC: out_d.flags_out = {z, exe_i.n, exe_i.h,
                                              exe_i.flags[calu_pkg::FlagC]};
      calu_pkg::FM_AND:    out_d.flags_out = {z, 1'b0, 1'b1, 1'b0};
      calu_pkg::FM_ZC:     out_d.flags_out = {z, 1'b0, 1'b0, exe_i.c};
      calu_pkg::FM_CPL:    out_d.flags_out = {exe_i.flags[calu_pkg::FlagZ], 1'b1, 1'b1,
                                              exe_i.flags[calu_pkg::FlagC]};
      default:             out_d.flags_out = exe_i.flags;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      out_q <= out_d;
    end
  end

  assign hs_o.valid = valid_q;
  assign hs_o.stall = stall;
  assign out_o      = out_q;

endmodule
